### src/tws_pkg.sv
// Shared types and constants for the Tahoe window sender.
`default_nettype none

package tws_pkg;

    // Field widths
    localparam int IDX_W = 24;
    localparam int WIN_W = 16;
    localparam int ID_W  = 16;
    localparam int CMD_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    // Port packing widths
    localparam int S_TDATA_W = 16;   // ack_id
    localparam int S_TUSER_W = 2;    // command
    localparam int M_TDATA_W = 80;   // send_first, send_last, window_now, threshold_now
    localparam int M_TUSER_W = 2;    // send_valid, complete

    // Packet ids wrap at this modulus; also the window ceiling
    localparam logic [ID_W-1:0]  ID_MODULUS = 16'hFFFF;
    localparam logic [WIN_W-1:0] WIN_MAX    = 16'hFFFF;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_PACKETS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_WINDOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [IDX_W-1:0] TOTAL_RESET     = 24'd1;
    localparam logic [WIN_W-1:0] WINDOW_RESET    = 16'd1;
    localparam logic [WIN_W-1:0] THRESHOLD_RESET = 16'd64;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  ack_id;
    } item_t;

    typedef struct packed {
        logic             send_valid;
        logic [IDX_W-1:0] send_first;
        logic [IDX_W-1:0] send_last;
        logic             complete;
        logic [WIN_W-1:0] window_now;
        logic [WIN_W-1:0] threshold_now;
    } result_t;

    // Packet id of an index: x mod 65535. Since 65536 = 1 mod 65535, the
    // high byte folds onto the low half; one subtract brings it into range.
    function automatic logic [ID_W-1:0] id_of(input logic [IDX_W-1:0] x);
        logic [ID_W:0] sum;
        logic [ID_W:0] reduced;
        begin
            sum = {9'b0, x[IDX_W-1:ID_W]} + {1'b0, x[ID_W-1:0]};
            reduced = sum - {1'b0, ID_MODULUS};
            if (sum >= {1'b0, ID_MODULUS}) begin
                id_of = reduced[ID_W-1:0];
            end else begin
                id_of = sum[ID_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

### src/tahoe_window_sender_top.sv
// Top level of the Tahoe window sender: input register, core, result register.
//
//  Channel  Direction  Handshake              Payload
//  s_       in         s_tvalid / s_tready    tdata ack_id, tuser command
//  m_       out        m_tvalid / m_tready    tdata range/window, tuser flags
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while m_tready keeps up; each request passes
// the input register, then the core update into the result register.
// The core's state update is a combinational compare/add path, so requests
// follow each other with no gap. cfg_ready is always high.
// aresetn is synchronous and active low; it empties both stages and loads
// the register reset values. A stalled m_tready holds the result register and
// then backs up into the input register.
`default_nettype none

module tahoe_window_sender_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // slave side
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [tws_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] ack_id
    input  wire logic [tws_pkg::S_TUSER_W-1:0]      s_tuser,   // [1:0] command
    // master side
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [23:0] send_first, [47:24] send_last, [63:48] window_now, [79:64] threshold_now
    output logic [tws_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic [tws_pkg::M_TUSER_W-1:0]           m_tuser,   // [0] send_valid, [1] complete
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tws_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tws_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tws_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    fire;
    logic    can_load;
    result_t result;
    result_t m_result;

    assign cfg_ready = 1'b1;

    assign s_item.command = s_tuser;
    assign s_item.ack_id  = s_tdata;

    // Core consumes a request only when the result register can take the result
    assign fire = item_valid && can_load;

    tws_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    tws_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    tws_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {m_result.threshold_now, m_result.window_now,
                      m_result.send_last, m_result.send_first};
    assign m_tuser = {m_result.complete, m_result.send_valid};

endmodule

`default_nettype wire

### src/tws_in_reg.sv
// Input register stage: holds one accepted request until the core takes it.
`default_nettype none

module tws_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tws_pkg::item_t s_item,
    output logic               item_valid,
    output tws_pkg::item_t     item,
    input  wire logic          item_take
);
    import tws_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Free to load when empty or when the held request leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

### src/tws_core.sv
// Sender state, configuration registers and per-event window update.
`default_nettype none

module tws_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_write,
    input  wire logic [tws_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tws_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               fire,
    input  wire tws_pkg::item_t                     item,
    output tws_pkg::result_t                        result
);
    import tws_pkg::*;

    // Configuration
    logic [IDX_W-1:0] total_reg;
    logic [WIN_W-1:0] init_win_reg;
    logic [WIN_W-1:0] init_thr_reg;

    // Transfer state
    logic [IDX_W-1:0] acked_reg, acked_next;
    logic [IDX_W-1:0] sent_reg, sent_next;
    logic [WIN_W-1:0] cwnd_reg, cwnd_next;
    logic [WIN_W-1:0] thr_reg, thr_next;
    logic             active_reg, active_next;

    // Event decode
    logic             is_start, is_ack, is_tmo;
    logic [IDX_W-1:0] acked_inc;
    logic [ID_W-1:0]  exp_id;
    logic             ack_match, ack_ahead, window_end, finish, advance, restart;
    logic             do_send;
    logic [WIN_W:0]   doubled;
    logic [WIN_W-1:0] grow_w, init_w, init_thr, half_w;
    logic [IDX_W-1:0] a_sel;
    logic [WIN_W-1:0] w_sel;

    // Next window range
    logic [IDX_W:0]   nw_raw, nw_end, nw_start;
    logic [IDX_W-1:0] nw_sent;
    logic             nw_empty;

    // Decode the event and pick the base index and window for the next send
    always_comb begin
        is_start  = (item.command == CMD_START);
        is_ack    = (item.command == CMD_ACK) && active_reg;
        is_tmo    = (item.command == CMD_TIMEOUT) && active_reg;
        acked_inc = acked_reg + 24'd1;
        exp_id    = id_of(acked_inc);
        ack_match = (item.ack_id == exp_id);
        ack_ahead = (item.ack_id > exp_id);
        window_end = ack_match && (item.ack_id == id_of(sent_reg));
        finish    = is_ack && window_end && (acked_inc == total_reg);
        advance   = is_ack && window_end && !finish;
        restart   = is_tmo || (is_ack && !ack_match && ack_ahead);
        do_send   = is_start || advance || restart;

        // Slow start doubles, congestion avoidance adds one; both saturate
        doubled = {cwnd_reg, 1'b0};
        if (cwnd_reg < thr_reg) begin
            grow_w = doubled[WIN_W] ? WIN_MAX : doubled[WIN_W-1:0];
        end else if (cwnd_reg < WIN_MAX) begin
            grow_w = cwnd_reg + 16'd1;
        end else begin
            grow_w = cwnd_reg;
        end

        init_w   = (init_win_reg == '0) ? 16'd1 : init_win_reg;
        init_thr = (init_thr_reg == '0) ? 16'd1 : init_thr_reg;
        half_w   = (cwnd_reg[WIN_W-1:1] == '0) ? 16'd1 : {1'b0, cwnd_reg[WIN_W-1:1]};

        if (is_start) begin
            a_sel = '0;
            w_sel = init_w;
        end else if (advance) begin
            a_sel = acked_inc;
            w_sel = grow_w;
        end else begin
            a_sel = acked_reg;
            w_sel = 16'd1;
        end
    end

    // Range of the next window, clipped at the last packet
    always_comb begin
        nw_raw   = {1'b0, a_sel} + {9'b0, w_sel};
        nw_end   = (nw_raw > {1'b0, total_reg}) ? {1'b0, total_reg} : nw_raw;
        nw_sent  = nw_end[IDX_W-1:0];
        nw_start = {1'b0, a_sel} + 25'd1;
        nw_empty = (nw_start > nw_end);
    end

    // State update and result
    always_comb begin
        acked_next  = acked_reg;
        sent_next   = sent_reg;
        cwnd_next   = cwnd_reg;
        thr_next    = thr_reg;
        active_next = active_reg;

        if (is_start) begin
            acked_next  = '0;
            thr_next    = init_thr;
            active_next = 1'b1;
        end else if (is_ack && ack_match) begin
            acked_next = acked_inc;
        end
        if (restart) begin
            thr_next = half_w;
        end
        if (finish) begin
            active_next = 1'b0;
        end
        if (do_send) begin
            sent_next = nw_sent;
            cwnd_next = w_sel;
        end

        result.send_valid    = do_send && !nw_empty;
        result.send_first    = result.send_valid ? nw_start[IDX_W-1:0] : '0;
        result.send_last     = result.send_valid ? nw_sent : '0;
        result.complete      = finish;
        result.window_now    = cwnd_next;
        result.threshold_now = thr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acked_reg  <= '0;
            sent_reg   <= '0;
            cwnd_reg   <= WINDOW_RESET;
            thr_reg    <= THRESHOLD_RESET;
            active_reg <= 1'b0;
        end else if (fire) begin
            acked_reg  <= acked_next;
            sent_reg   <= sent_next;
            cwnd_reg   <= cwnd_next;
            thr_reg    <= thr_next;
            active_reg <= active_next;
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= TOTAL_RESET;
            init_win_reg <= WINDOW_RESET;
            init_thr_reg <= THRESHOLD_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_TOTAL_PACKETS:     total_reg    <= cfg_data;
                REG_INITIAL_WINDOW:    init_win_reg <= cfg_data[WIN_W-1:0];
                REG_INITIAL_THRESHOLD: init_thr_reg <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/tws_out_reg.sv
// Result register stage: holds one result until the downstream side takes it.
`default_nettype none

module tws_out_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  wire tws_pkg::result_t result,
    output logic               can_load,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tws_pkg::result_t   m_result
);
    import tws_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

### tb/sv/tahoe_window_sender_top_tb.sv
// Self-checking testbench for the Tahoe window sender top level.
`default_nettype none

module tahoe_window_sender_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tws_pkg::*;

    // Command code with no action in the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned IDX_MASK = (1 << IDX_W) - 1;
    localparam int LIVE_PER_PHASE = 130;
    localparam int RANDOM_PHASES = 12;
    localparam int LONG_HOLD = 300;

    // Scoreboard: window predictor plus the queue of send orders still due
    class tws_scoreboard;
        int unsigned total_cfg;
        int unsigned window_cfg;
        int unsigned thresh_cfg;
        int unsigned acked_idx;
        int unsigned sent_idx;
        int unsigned cwnd;
        int unsigned ssthresh;
        bit          active;
        result_t     sends_due[$];
        int          mismatches;

        function new();
            total_cfg  = 32'(TOTAL_RESET);
            window_cfg = 32'(WINDOW_RESET);
            thresh_cfg = 32'(THRESHOLD_RESET);
            acked_idx  = 0;
            sent_idx   = 0;
            cwnd       = 1;
            ssthresh   = 32'(THRESHOLD_RESET);
            active     = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TOTAL_PACKETS:     total_cfg  = 32'(data);
                REG_INITIAL_WINDOW:    window_cfg = 32'(data[WIN_W-1:0]);
                REG_INITIAL_THRESHOLD: thresh_cfg = 32'(data[WIN_W-1:0]);
                default: ;
            endcase
        endfunction

        // Next window from the first unacked packet, clipped to the message end
        function bit open_window(output logic [IDX_W-1:0] first_idx,
                                 output logic [IDX_W-1:0] last_idx);
            int unsigned end_idx;
            end_idx = acked_idx + cwnd;
            if (end_idx > total_cfg) end_idx = total_cfg;
            sent_idx = end_idx & IDX_MASK;
            first_idx = '0;
            last_idx = '0;
            if (acked_idx + 1 > end_idx) return 1'b0;
            first_idx = IDX_W'((acked_idx + 1) & IDX_MASK);
            last_idx = IDX_W'(sent_idx);
            return 1'b1;
        endfunction

        // Loss detected: halve threshold, restart slow start
        function void collapse();
            ssthresh = (cwnd >> 1) < 1 ? 1 : (cwnd >> 1);
            cwnd = 1;
            sent_idx = acked_idx;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
            result_t     r;
            int unsigned want;
            r = '0;
            case (cmd)
                CMD_START: begin
                    acked_idx = 0;
                    cwnd = window_cfg != 0 ? window_cfg : 1;
                    ssthresh = thresh_cfg != 0 ? thresh_cfg : 1;
                    active = 1'b1;
                    r.send_valid = open_window(r.send_first, r.send_last);
                end
                CMD_ACK: begin
                    if (active) begin
                        want = ((acked_idx + 1) & IDX_MASK) % ID_MODULUS;
                        if (id == want) begin
                            acked_idx = (acked_idx + 1) & IDX_MASK;
                            // last packet of the window acked
                            if (id == sent_idx % ID_MODULUS) begin
                                if (acked_idx == total_cfg) begin
                                    r.complete = 1'b1;
                                    active = 1'b0;
                                end else begin
                                    if (cwnd < ssthresh) begin
                                        cwnd = cwnd << 1;
                                        if (cwnd > WIN_MAX) cwnd = WIN_MAX;
                                    end else if (cwnd < WIN_MAX) begin
                                        cwnd++;
                                    end
                                    r.send_valid = open_window(r.send_first, r.send_last);
                                end
                            end
                        end else if (id > want) begin
                            collapse();
                            r.send_valid = open_window(r.send_first, r.send_last);
                        end
                    end
                end
                CMD_TIMEOUT: begin
                    if (active) begin
                        collapse();
                        r.send_valid = open_window(r.send_first, r.send_last);
                    end
                end
                default: ;
            endcase
            r.window_now = WIN_W'(cwnd);
            r.threshold_now = WIN_W'(ssthresh);
            sends_due = {sends_due, r};
        endfunction

        function void cmp_field(string name, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t",
                             name, want_v, got_v, $realtime);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (sends_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result 0x%0h at %0t", got, $realtime);
                return;
            end
            want = sends_due.pop_front();
            cmp_field("send_valid", want.send_valid, got.send_valid);
            cmp_field("send_first", want.send_first, got.send_first);
            cmp_field("send_last", want.send_last, got.send_last);
            cmp_field("complete", want.complete, got.complete);
            cmp_field("window_now", want.window_now, got.window_now);
            cmp_field("threshold_now", want.threshold_now, got.threshold_now);
        endfunction

        function int pending();
            return sends_due.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // [15:0] ack_id
    logic [S_TUSER_W-1:0] s_tuser = '0;    // [1:0] command
    logic m_tvalid;
    logic m_tready = 1'b0;
    // [23:0] send_first, [47:24] send_last, [63:48] window_now, [79:64] threshold_now
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;         // [0] send_valid, [1] complete
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tws_scoreboard sb;
    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;
    int hold_req = 0;
    int live_reqs = 0;

    always #5 aclk = ~aclk;

    tahoe_window_sender_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Offer one request and wait for it to be taken; valid stays up afterwards
    task automatic drive_req(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= id;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_START || (sb.active && (cmd == CMD_ACK || cmd == CMD_TIMEOUT)))
            live_reqs++;
        sb.note_request(cmd, id);
    endtask

    // Drop valid and wait until every send order has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_one(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic write_config(input logic [IDX_W-1:0] total,
                                input logic [WIN_W-1:0] win,
                                input logic [WIN_W-1:0] thr);
        write_one(REG_TOTAL_PACKETS, total);
        write_one(REG_INITIAL_WINDOW, {8'd0, win});
        write_one(REG_INITIAL_THRESHOLD, {8'd0, thr});
        cfg_valid <= 1'b0;
    endtask

    // Mostly in-order acks of a live transfer; losses, stale ids and noise mixed in
    task automatic pick_req(output logic [CMD_W-1:0] cmd, output logic [ID_W-1:0] id);
        int unsigned want;
        int unsigned r;
        want = ((sb.acked_idx + 1) & IDX_MASK) % ID_MODULUS;
        id = ID_W'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (!sb.active) begin
            if (r < 85) cmd = CMD_START;
            else if (r < 92) cmd = CMD_ACK;
            else if (r < 97) cmd = CMD_TIMEOUT;
            else cmd = CMD_UNUSED;
        end else if (r < 75) begin
            cmd = CMD_ACK;
            id = ID_W'(want);
        end else if (r < 80) begin
            cmd = CMD_ACK;
            if (want > 0) id = ID_W'($urandom_range(0, want - 1));
        end else if (r < 84) begin
            cmd = CMD_ACK;
            id = ID_W'($urandom_range(want + 1, 65535));
        end else if (r < 88) begin
            cmd = CMD_TIMEOUT;
        end else if (r < 91) begin
            cmd = CMD_START;
        end else if (r < 94) begin
            cmd = CMD_UNUSED;
        end else begin
            cmd = CMD_W'($urandom_range(0, 3));
        end
    endtask

    // Result side: random stalls, one long hold on request
    initial begin
        int gap;
        result_t got;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req > 0) begin
                gap = hold_req;
                hold_req = 0;
            end else begin
                gap = recv_gaps ? $urandom_range(0, 9) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.send_valid = m_tuser[0];
            got.complete = m_tuser[1];
            got.send_first = m_tdata[23:0];
            got.send_last = m_tdata[47:24];
            got.window_now = m_tdata[63:48];
            got.threshold_now = m_tdata[79:64];
            sb.check_result(got);
        end
    end

    // Stimulus and verdict
    initial begin
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0] id;
        logic [IDX_W-1:0] total;
        logic [WIN_W-1:0] win;
        logic [WIN_W-1:0] thr;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: idle events, unused command, one-packet transfer
        drive_req(CMD_ACK, 16'd1);
        drive_req(CMD_TIMEOUT, 16'd0);
        drive_req(CMD_UNUSED, 16'hFFFF);
        drive_req(CMD_START, 16'h0000);
        drive_req(CMD_ACK, 16'd0);
        drive_req(CMD_ACK, 16'd1);
        drive_req(CMD_UNUSED, 16'h5A5A);
        drain();

        // Zero registers load as one; growth, loss, timeout, restart while active
        write_config(24'hFFFFFF, 16'd0, 16'd0);
        drive_req(CMD_START, 16'hFFFF);
        drive_req(CMD_ACK, 16'd1);
        drive_req(CMD_ACK, 16'd5);
        drive_req(CMD_TIMEOUT, 16'hA5A5);
        drive_req(CMD_ACK, 16'hFFFF);
        drive_req(CMD_START, 16'd0);
        drive_req(CMD_ACK, 16'd1);
        drain();

        // Widest window clipped to the message end
        write_config(24'd3, 16'hFFFF, 16'hFFFF);
        drive_req(CMD_START, 16'd0);
        drive_req(CMD_ACK, 16'd1);
        drive_req(CMD_ACK, 16'd2);
        drive_req(CMD_ACK, 16'd3);
        drain();

        // Doubling, then shrink the message under the acked point: empty window
        write_config(24'd8, 16'd2, 16'hFFFF);
        drive_req(CMD_START, 16'd0);
        drive_req(CMD_ACK, 16'd1);
        drive_req(CMD_ACK, 16'd2);
        drain();
        write_config(24'd1, 16'd2, 16'hFFFF);
        drive_req(CMD_ACK, 16'd3);
        drive_req(CMD_TIMEOUT, 16'd0);
        drive_req(CMD_START, 16'd0);
        drive_req(CMD_ACK, 16'd1);
        drain();

        // Random phases, each with its own register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0: total = 24'd1;
                1: total = 24'hFFFFFF;
                2: total = IDX_W'($urandom);
                default: total = IDX_W'($urandom_range(2, 300));
            endcase
            case ($urandom_range(0, 5))
                0: win = 16'd0;
                1: win = 16'hFFFF;
                2: win = 16'd1;
                default: win = WIN_W'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 5))
                0: thr = 16'd0;
                1: thr = 16'hFFFF;
                2: thr = 16'd1;
                default: thr = WIN_W'($urandom_range(1, 64));
            endcase
            write_config(total, win, thr);
            send_gaps = $urandom_range(0, 3) != 0;
            recv_gaps = $urandom_range(0, 3) != 0;
            // back-pressure: result side holds off while requests keep coming
            if (ph == 2) begin
                send_gaps = 1'b0;
                hold_req = LONG_HOLD;
            end
            live_reqs = 0;
            while (live_reqs < LIVE_PER_PHASE) begin
                pick_req(cmd, id);
                drive_req(cmd, id);
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### tahoe_window_sender_top.f
src/tws_pkg.sv
src/tws_in_reg.sv
src/tws_core.sv
src/tws_out_reg.sv
src/tahoe_window_sender_top.sv
tb/sv/tahoe_window_sender_top_tb.sv
